@@ design/dssm_pkg.sv @@
// Shared types and constants for the deployment signal state machine core.
// Holds deployment state codes, version-word match constants and register indexes.
// No dependencies.
package dssm_pkg;

   // Deployment state codes
   localparam logic [2:0] ST_DEFINED = 3'd0;
   localparam logic [2:0] ST_STARTED = 3'd1;
   localparam logic [2:0] ST_LOCKED  = 3'd2;
   localparam logic [2:0] ST_ACTIVE  = 3'd3;
   localparam logic [2:0] ST_FAILED  = 3'd4;

   // Top bits of the version word that mark a version-bits header
   localparam logic [31:0] TOP_MASK    = 32'hE000_0000;
   localparam logic [31:0] TOP_PATTERN = 32'h2000_0000;

   // Configuration register indexes
   localparam logic [2:0] REG_SIGNAL_BIT    = 3'd0;
   localparam logic [2:0] REG_START_TIME    = 3'd1;
   localparam logic [2:0] REG_TIMEOUT_TIME  = 3'd2;
   localparam logic [2:0] REG_WINDOW_LENGTH = 3'd3;
   localparam logic [2:0] REG_THRESHOLD     = 3'd4;
   localparam logic [2:0] REG_GRACE_BLOCKS  = 3'd5;
   localparam logic [2:0] REG_GRACE_TIME    = 3'd6;

   // Field widths
   localparam int VER_W  = 32;
   localparam int TIME_W = 32;
   localparam int HGT_W  = 31;
   localparam int CFG_W  = 63;
   localparam int WIN_W  = 16;

   // Remainder pipeline: (height + 1) is VER_W-wide, four bits per stage
   localparam int DVD_W       = HGT_W + 1;
   localparam int DIV_STEP    = 4;
   localparam int DIV_STAGES  = DVD_W / DIV_STEP;

   typedef logic [2:0] phase_type;

   // One item as it travels down the remainder pipeline
   typedef struct packed {
      logic              sig;
      logic [TIME_W-1:0] mtime;
      logic [HGT_W-1:0]  height;
      logic [DVD_W-1:0]  dividend;
      logic [WIN_W-1:0]  remainder;
   } stage_type;

endpackage

@@ design/deployment_signal_state_machine_core.sv @@
// Deployment signal state machine core: top level.
// Streams block headers in, tracks a version-bits deployment, streams state out.
// Depends on dssm_pkg.

// Takes one block header item per cycle (version word, median time past,
// height) and returns one result item per header: the deployment state for
// the following blocks, a last flag on the header that closes a counting
// window, and the signalling count of the window so far. A new item is
// accepted every cycle while the result side keeps up. Each item passes ten
// registers: one input register, eight stages of the remainder pipeline that
// works out (height + 1) mod window_length four bits per stage, and the
// state/result register. A stalled result stalls the whole pipeline.
// Configuration must be written only while no item is in flight; the core
// itself does not enforce this.
module deployment_signal_state_machine_core
   import dssm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Header items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // [31:0] version_word, [63:32] median_time,
                                    // [94:64] block_height, [95] zero
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] deployment_state, [18:3] window_signals,
                                    // [23:19] zero
   output logic        rsp_tlast,   // window_end
   // Configuration writes
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [62:0] csr_wdata
);

   // Configuration registers
   logic [4:0]        signal_bit_ff;
   logic [CFG_W-1:0]  start_time_ff;
   logic [CFG_W-1:0]  timeout_time_ff;
   logic [WIN_W-1:0]  window_length_ff;
   logic [WIN_W-1:0]  threshold_ff;
   logic [HGT_W-1:0]  grace_blocks_ff;
   logic [TIME_W-1:0] grace_time_ff;

   // Pipeline
   logic                advance;
   logic [DIV_STAGES:0] vld_ff;
   stage_type           stage_ff [0:DIV_STAGES];
   stage_type           stage_in [0:DIV_STAGES];

   // Deployment state
   phase_type         phase_ff, phase_in;
   logic [WIN_W-1:0]  tally_ff, tally_in;
   logic [HGT_W-1:0]  lock_hgt_ff, lock_hgt_in;
   logic [TIME_W-1:0] lock_time_ff, lock_time_in;

   // Result register
   logic              rsp_vld_ff;
   phase_type         rsp_phase_ff, rsp_phase_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [WIN_W-1:0]  rsp_sig_ff, rsp_sig_in;

   // Final-stage decode
   stage_type         fin;
   logic [WIN_W-1:0]  tally_inc;
   logic              at_end;
   logic              past_timeout;
   logic              past_start;
   logic [TIME_W:0]   time_due;
   logic [HGT_W:0]    hgt_due;
   logic              grace_done;

   // Move everything when the result register is free or being taken
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign req_tready = advance;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'd0, rsp_sig_ff, rsp_phase_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Configuration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         signal_bit_ff    <= '0;
         start_time_ff    <= '0;
         timeout_time_ff  <= {CFG_W{1'b1}};
         window_length_ff <= WIN_W'(2016);
         threshold_ff     <= WIN_W'(1916);
         grace_blocks_ff  <= '0;
         grace_time_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_SIGNAL_BIT:    signal_bit_ff    <= csr_wdata[4:0];
            REG_START_TIME:    start_time_ff    <= csr_wdata;
            REG_TIMEOUT_TIME:  timeout_time_ff  <= csr_wdata;
            REG_WINDOW_LENGTH: window_length_ff <= csr_wdata[WIN_W-1:0];
            REG_THRESHOLD:     threshold_ff     <= csr_wdata[WIN_W-1:0];
            REG_GRACE_BLOCKS:  grace_blocks_ff  <= csr_wdata[HGT_W-1:0];
            REG_GRACE_TIME:    grace_time_ff    <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Input stage and remainder steps, four dividend bits per stage
   always_comb begin
      logic [WIN_W:0]   rem_v;
      logic [DVD_W-1:0] dvd_v;
      stage_in[0].sig       = ((req_tdata[31:0] & TOP_MASK) == TOP_PATTERN)
                              && req_tdata[signal_bit_ff];
      stage_in[0].mtime     = req_tdata[63:32];
      stage_in[0].height    = req_tdata[94:64];
      stage_in[0].dividend  = {1'b0, req_tdata[94:64]} + DVD_W'(1);
      stage_in[0].remainder = '0;
      for (int k = 1; k <= DIV_STAGES; k++) begin
         rem_v = {1'b0, stage_ff[k-1].remainder};
         dvd_v = stage_ff[k-1].dividend;
         for (int j = 0; j < DIV_STEP; j++) begin
            rem_v = {rem_v[WIN_W-1:0], dvd_v[DVD_W-1]};
            dvd_v = {dvd_v[DVD_W-2:0], 1'b0};
            if (rem_v >= {1'b0, window_length_ff}) begin
               rem_v = rem_v - {1'b0, window_length_ff};
            end
         end
         stage_in[k]           = stage_ff[k-1];
         stage_in[k].dividend  = dvd_v;
         stage_in[k].remainder = rem_v[WIN_W-1:0];
      end
   end

   // Advance the pipeline payload and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DIV_STAGES-1:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // Window tally, window-end evaluation and result
   assign fin          = stage_ff[DIV_STAGES];
   assign tally_inc    = (fin.sig && (tally_ff != {WIN_W{1'b1}})) ? tally_ff + WIN_W'(1)
                                                                   : tally_ff;
   assign at_end       = (fin.remainder == '0);
   assign past_timeout = {{(CFG_W-TIME_W){1'b0}}, fin.mtime} >= timeout_time_ff;
   assign past_start   = {{(CFG_W-TIME_W){1'b0}}, fin.mtime} >= start_time_ff;
   assign time_due     = {1'b0, lock_time_ff} + {1'b0, grace_time_ff};
   assign hgt_due      = {1'b0, lock_hgt_ff} + {1'b0, grace_blocks_ff};
   assign grace_done   = ({1'b0, fin.mtime} >= time_due) && ({1'b0, fin.height} >= hgt_due);

   always_comb begin
      phase_in     = phase_ff;
      tally_in     = tally_ff;
      lock_hgt_in  = lock_hgt_ff;
      lock_time_in = lock_time_ff;
      rsp_phase_in = phase_ff;
      rsp_last_in  = 1'b0;
      rsp_sig_in   = '0;
      if (window_length_ff == '0) begin
         // Undefined deployment: clear everything and report defined
         phase_in     = ST_DEFINED;
         tally_in     = '0;
         lock_hgt_in  = '0;
         lock_time_in = '0;
         rsp_phase_in = ST_DEFINED;
      end else begin
         tally_in   = tally_inc;
         rsp_sig_in = tally_inc;
         if (at_end) begin
            tally_in    = '0;
            rsp_last_in = 1'b1;
            case (phase_ff)
               ST_DEFINED: begin
                  if (past_timeout) begin
                     phase_in = ST_FAILED;
                  end else if (past_start) begin
                     phase_in = ST_STARTED;
                  end
               end
               ST_STARTED: begin
                  if (past_timeout) begin
                     phase_in = ST_FAILED;
                  end else if (tally_inc >= threshold_ff) begin
                     phase_in     = ST_LOCKED;
                     lock_hgt_in  = fin.height;
                     lock_time_in = fin.mtime;
                  end
               end
               ST_LOCKED: begin
                  if (grace_done) begin
                     phase_in = ST_ACTIVE;
                  end
               end
               default: ;
            endcase
         end
         rsp_phase_in = phase_in;
      end
   end

   // Hold state and result; update when the last stage item moves out
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ST_DEFINED;
         tally_ff     <= '0;
         lock_hgt_ff  <= '0;
         lock_time_ff <= '0;
         rsp_vld_ff   <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= vld_ff[DIV_STAGES];
         if (vld_ff[DIV_STAGES]) begin
            phase_ff     <= phase_in;
            tally_ff     <= tally_in;
            lock_hgt_ff  <= lock_hgt_in;
            lock_time_ff <= lock_time_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && vld_ff[DIV_STAGES]) begin
         rsp_phase_ff <= rsp_phase_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_sig_ff   <= rsp_sig_in;
      end
   end

endmodule

@@ bench/deployment_signal_state_machine_core_test.sv @@
// Self-checking bench for deployment_signal_state_machine_core.
// Streams block-header items through the core, predicts each result item and
// compares it. Depends on dssm_pkg and the core RTL.
`timescale 1ns / 1ps

module deployment_signal_state_machine_core_test;
   import dssm_pkg::*;

   typedef struct {
      logic [31:0] version;
      logic [31:0] mtime;
      logic [30:0] height;
   } header_type;

   typedef struct {
      phase_type   state;
      logic        closes;
      logic [15:0] signals;
   } deployment_result_type;

   localparam logic [62:0] TIME_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = REG_SIGNAL_BIT;
   logic [62:0] csr_wdata = '0;

   deployment_signal_state_machine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Configuration as the core holds it
   logic [4:0]  cfg_signal_bit   = 5'd0;
   logic [62:0] cfg_start        = '0;
   logic [62:0] cfg_timeout      = TIME_MAX;
   logic [15:0] cfg_window       = 16'd2016;
   logic [15:0] cfg_threshold    = 16'd1916;
   logic [30:0] cfg_grace_blocks = '0;
   logic [31:0] cfg_grace_time   = '0;

   // Deployment tracking state
   phase_type   deploy_phase = ST_DEFINED;
   logic [15:0] window_tally = '0;
   logic [63:0] lockin_h     = '0;
   logic [63:0] lockin_t     = '0;

   header_type            header_queue[$];
   deployment_result_type predicted_states[$];

   int  mismatches = 0;
   int  headers_sent = 0;
   int  results_checked = 0;
   int  window_closes = 0;
   int  config_count = 0;
   bit  [4:0] states_seen = '0;
   bit  calm = 1'b0;
   bit  long_hold_req = 1'b0;
   int  gap_left = 0;
   int  hold_left = 0;

   // Advance the deployment by one header and return the result it yields
   function automatic deployment_result_type advance_deployment(logic [31:0] ver,
                                                                logic [31:0] t,
                                                                logic [30:0] h);
      deployment_result_type r;
      logic signalling;
      logic [63:0] t64;
      logic [63:0] h64;
      t64 = 64'(t);
      h64 = 64'(h);
      if (cfg_window == 16'd0) begin
         deploy_phase = ST_DEFINED;
         window_tally = '0;
         lockin_h = '0;
         lockin_t = '0;
         r.state = ST_DEFINED;
         r.closes = 1'b0;
         r.signals = '0;
         return r;
      end
      signalling = ((ver & TOP_MASK) == TOP_PATTERN) && ver[cfg_signal_bit];
      if (signalling && window_tally != 16'hFFFF)
         window_tally = window_tally + 16'd1;
      r.signals = window_tally;
      r.closes = ((h64 + 64'd1) % 64'(cfg_window)) == 64'd0;
      if (r.closes) begin
         case (deploy_phase)
            ST_DEFINED: begin
               if (t64 >= 64'(cfg_timeout))
                  deploy_phase = ST_FAILED;
               else if (t64 >= 64'(cfg_start))
                  deploy_phase = ST_STARTED;
            end
            ST_STARTED: begin
               if (t64 >= 64'(cfg_timeout)) begin
                  deploy_phase = ST_FAILED;
               end else if (window_tally >= cfg_threshold) begin
                  deploy_phase = ST_LOCKED;
                  lockin_h = h64;
                  lockin_t = t64;
               end
            end
            ST_LOCKED: begin
               if (t64 >= lockin_t + 64'(cfg_grace_time) &&
                   h64 >= lockin_h + 64'(cfg_grace_blocks))
                  deploy_phase = ST_ACTIVE;
            end
            default: ;
         endcase
         window_tally = '0;
      end
      r.state = deploy_phase;
      return r;
   endfunction

   // Sender: predict on each accepted item, then offer the next pending one
   always @(posedge clock) begin
      header_type hdr;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_states.insert(predicted_states.size(),
                                    advance_deployment(req_tdata[31:0],
                                                       req_tdata[63:32],
                                                       req_tdata[94:64]));
            headers_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (header_queue.size() != 0 && !calm &&
                         $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(0, 8);
               req_tvalid <= 1'b0;
            end else if (header_queue.size() != 0) begin
               hdr = header_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {1'b0, hdr.height, hdr.mtime, hdr.version};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each accepted result, then decide whether to stall
   always @(posedge clock) begin
      deployment_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_states.size() == 0) begin
               $display("%0t: result with nothing expected: state %0d last %0b signals %0d",
                        $time, rsp_tdata[2:0], rsp_tlast, rsp_tdata[18:3]);
               mismatches++;
            end else begin
               want = predicted_states.pop_front();
               results_checked++;
               if (rsp_tdata[2:0] !== want.state) begin
                  $display("%0t: deployment_state expected %0d actual %0d",
                           $time, want.state, rsp_tdata[2:0]);
                  mismatches++;
               end
               if (rsp_tlast !== want.closes) begin
                  $display("%0t: window_end expected %0b actual %0b",
                           $time, want.closes, rsp_tlast);
                  mismatches++;
               end
               if (rsp_tdata[18:3] !== want.signals) begin
                  $display("%0t: window_signals expected %0d actual %0d",
                           $time, want.signals, rsp_tdata[18:3]);
                  mismatches++;
               end
               if (want.closes)
                  window_closes++;
               if (want.state <= ST_FAILED)
                  states_seen[want.state] = 1'b1;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 300;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Drive one register write; the predictor copy follows it
   task automatic write_register(input logic [2:0] idx, input logic [62:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_SIGNAL_BIT:    cfg_signal_bit   = value[4:0];
         REG_START_TIME:    cfg_start        = value;
         REG_TIMEOUT_TIME:  cfg_timeout      = value;
         REG_WINDOW_LENGTH: cfg_window       = value[15:0];
         REG_THRESHOLD:     cfg_threshold    = value[15:0];
         REG_GRACE_BLOCKS:  cfg_grace_blocks = value[30:0];
         REG_GRACE_TIME:    cfg_grace_time   = value[31:0];
         default: ;
      endcase
   endtask

   task automatic finish_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
      config_count++;
      @(negedge clock);
   endtask

   task automatic queue_header(input logic [31:0] ver, input logic [31:0] t,
                               input logic [30:0] h);
      header_type hdr;
      hdr.version = ver;
      hdr.mtime = t;
      hdr.height = h;
      header_queue.insert(header_queue.size(), hdr);
   endtask

   // Wait until every item is in and every result is out, then let the pipe drain
   task automatic wait_idle();
      do
         @(negedge clock);
      while (header_queue.size() != 0 || req_tvalid || predicted_states.size() != 0);
      repeat (12) @(negedge clock);
   endtask

   initial begin
      #3_000_000;
      $display("timeout with %0d items pending and %0d results outstanding",
               header_queue.size(), predicted_states.size());
      $display("status: fail");
      $finish;
   end

   initial begin
      int unsigned wl;
      int unsigned n;
      int unsigned p;
      int unsigned d;
      int unsigned span;
      int unsigned random_items;
      int phase_no;
      logic [31:0] t_now;
      logic [31:0] t0;
      logic [31:0] t_item;
      logic [31:0] ver;
      logic [30:0] h_now;
      logic [30:0] h_item;
      logic [4:0]  sb;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every block closes a window; zero threshold locks at the next window end; field extremes
      write_register(REG_SIGNAL_BIT, 63'd0);
      write_register(REG_START_TIME, 63'd0);
      write_register(REG_TIMEOUT_TIME, TIME_MAX);
      write_register(REG_WINDOW_LENGTH, 63'd1);
      write_register(REG_THRESHOLD, 63'd0);
      write_register(REG_GRACE_BLOCKS, 63'd0);
      write_register(REG_GRACE_TIME, 63'd0);
      finish_writes();
      queue_header(32'h0000_0000, 32'h0000_0000, 31'd0);
      queue_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd1);
      queue_header(TOP_PATTERN | 32'd1, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      wait_idle();

      // Zero window length clears the deployment
      write_register(REG_WINDOW_LENGTH, 63'd0);
      finish_writes();
      queue_header(32'h2000_0001, 32'h1234_5678, 31'd3);
      wait_idle();

      // Bit 29 rides on the top pattern; walk defined, started, locked, active,
      // with heights out of order and median time going back at the end
      write_register(REG_SIGNAL_BIT, 63'd29);
      write_register(REG_START_TIME, 63'd100);
      write_register(REG_TIMEOUT_TIME, 63'd1000);
      write_register(REG_WINDOW_LENGTH, 63'd4);
      write_register(REG_THRESHOLD, 63'd4);
      write_register(REG_GRACE_BLOCKS, 63'd4);
      write_register(REG_GRACE_TIME, 63'd50);
      finish_writes();
      for (int i = 0; i < 4; i++)
         queue_header(TOP_PATTERN, (i == 3) ? 32'd100 : 32'd50, 31'(i));
      for (int i = 4; i < 8; i++)
         queue_header(TOP_PATTERN, 32'd200, 31'(i));
      for (int i = 8; i < 12; i++)
         queue_header(32'h4000_0000, 32'd240, 31'(i));
      queue_header(32'hFFFF_FFFF, 32'd300, 31'd15);
      queue_header(TOP_PATTERN, 32'd10, 31'd3);
      wait_idle();

      // Timeout at zero fails at the first window end; other registers but window length at extremes
      write_register(REG_WINDOW_LENGTH, 63'd0);
      finish_writes();
      queue_header(32'hDEAD_BEEF, 32'd7, 31'd9);
      wait_idle();
      write_register(REG_SIGNAL_BIT, 63'd31);
      write_register(REG_START_TIME, TIME_MAX);
      write_register(REG_TIMEOUT_TIME, 63'd0);
      write_register(REG_WINDOW_LENGTH, 63'd2);
      write_register(REG_THRESHOLD, 63'd65535);
      write_register(REG_GRACE_BLOCKS, 63'h7FFF_FFFF);
      write_register(REG_GRACE_TIME, 63'hFFFF_FFFF);
      finish_writes();
      queue_header(32'hA000_0000, 32'd5, 31'd0);
      queue_header(TOP_PATTERN, 32'd5, 31'd1);
      wait_idle();

      // Random header runs, each under a fresh configuration
      random_items = 0;
      phase_no = 0;
      while (random_items < 1100) begin
         calm = (random_items >= 950) || ($urandom_range(0, 4) == 0);

         // Usually clear the deployment first so every state stays reachable
         if ($urandom_range(0, 3) != 0) begin
            write_register(REG_WINDOW_LENGTH, 63'd0);
            finish_writes();
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++)
               queue_header($urandom, $urandom, 31'($urandom));
            random_items += n;
            wait_idle();
         end

         n = $urandom_range(20, 80);
         span = n * 300;
         sb = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(29, 31))
                                         : 5'($urandom_range(0, 28));
         case ($urandom_range(0, 19))
            0:       wl = 65535;
            1:       wl = $urandom_range(13, 65534);
            default: wl = $urandom_range(1, 12);
         endcase
         t0 = $urandom_range(0, 32'hFFF0_0000);
         write_register(REG_SIGNAL_BIT, 63'(sb));
         case ($urandom_range(0, 7))
            0:       write_register(REG_START_TIME, 63'd0);
            1:       write_register(REG_START_TIME, TIME_MAX);
            default: write_register(REG_START_TIME, 63'(t0) + 63'($urandom_range(0, span)));
         endcase
         case ($urandom_range(0, 7))
            0:       write_register(REG_TIMEOUT_TIME, 63'd0);
            1, 2:    write_register(REG_TIMEOUT_TIME, TIME_MAX);
            default: write_register(REG_TIMEOUT_TIME,
                                    63'(t0) + 63'($urandom_range(span / 4, span * 2)));
         endcase
         write_register(REG_WINDOW_LENGTH, 63'(wl));
         case ($urandom_range(0, 9))
            0:       write_register(REG_THRESHOLD, 63'd0);
            1:       write_register(REG_THRESHOLD, 63'd65535);
            default: write_register(REG_THRESHOLD, 63'($urandom_range(0, wl)));
         endcase
         if ($urandom_range(0, 9) == 0)
            write_register(REG_GRACE_BLOCKS, 63'h7FFF_FFFF);
         else
            write_register(REG_GRACE_BLOCKS, 63'($urandom_range(0, 3 * wl)));
         if ($urandom_range(0, 9) == 0)
            write_register(REG_GRACE_TIME, 63'hFFFF_FFFF);
         else
            write_register(REG_GRACE_TIME, 63'($urandom_range(0, 2000)));
         finish_writes();

         // Start at zero or just short of some window end
         if ($urandom_range(0, 2) == 0) begin
            h_now = '0;
         end else begin
            d = $urandom_range(1, (wl < 40) ? wl : 40);
            h_now = 31'(($urandom_range(0, 32'h7FF0_0000) / wl) * wl + wl - d);
         end
         t_now = t0;
         p = $urandom_range(0, 100);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < p) begin
               ver = TOP_PATTERN | ($urandom & ~TOP_MASK);
               ver[sb] = 1'b1;
            end else if ($urandom_range(0, 1) == 0) begin
               ver = $urandom;
            end else begin
               ver = TOP_PATTERN | ($urandom & ~TOP_MASK);
               ver[sb] = 1'b0;
            end
            h_item = h_now;
            t_item = t_now;
            // Now and then break the height order or send median time back
            if ($urandom_range(0, 29) == 0) begin
               if ($urandom_range(0, 1) == 0)
                  h_item = 31'($urandom);
               else
                  t_item = t_now - $urandom_range(1, 1000);
            end
            queue_header(ver, t_item, h_item);
            h_now = h_now + 31'd1;
            t_now = t_now + $urandom_range(0, 600);
         end
         random_items += n;
         // Hold the result side off once so the core backs up into its input
         if (phase_no == 3)
            long_hold_req = 1'b1;
         phase_no++;
         wait_idle();
      end

      $display("covered %0d header items over %0d configurations, %0d results checked",
               headers_sent, config_count, results_checked);
      $display("%0d window closes seen, deployment states reached (bit per state) %05b",
               window_closes, states_seen);
      if (mismatches == 0 && predicted_states.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
